>>> hw/rtl/wlac_pkg.sv
// Shared types and constants of the wake light alarm controller.
package wlac_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] RegDimStart  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDimStop   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHoldLevel = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRampSec   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHoldSec   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPwmTop    = 3'd5;

  localparam logic [2:0] CmdPwmTick  = 3'd0;
  localparam logic [2:0] CmdSecTick  = 3'd1;
  localparam logic [2:0] CmdCheck    = 3'd2;
  localparam logic [2:0] CmdSetTime  = 3'd3;
  localparam logic [2:0] CmdAdd      = 3'd4;
  localparam logic [2:0] CmdDelete   = 3'd5;
  localparam logic [2:0] CmdManual   = 3'd6;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StBadData   = 2'd1;
  localparam logic [1:0] StNoSlot    = 2'd2;
  localparam logic [1:0] StBadSlot   = 2'd3;

  // Wake entry as stored in the table memory: enable, day, hour, minute.
  localparam int unsigned EntryW = 15;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] day_value;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
    logic [7:0] slot_index;
    logic [7:0] intensity_value;
  } in_word_t;

  typedef struct packed {
    logic       led_on;
    logic [7:0] intensity;
    logic [1:0] status;
    logic [2:0] clock_day;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;
  } out_word_t;

endpackage

>>> hw/rtl/wlac_ram.sv
// Generic single-port RAM with registered read.
module wlac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write or read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hw/rtl/wake_light_alarm_controller.sv
// Top level of the wake light alarm controller.
// One command word is taken when start is high and busy low; its result
// word shows on result_o for one cycle with done_o high, and the receiver
// cannot hold it off. Ticks, set time and manual intensity go straight from
// idle to the done state. Add and alarm check walk the wake table memory
// one entry a cycle (an alarm check under manual intensity skips the walk);
// delete reads the named entry and writes it back disabled. The ramp fraction
// comes from a one-bit-a-cycle divider. After reset a clearing pass disables
// every table entry; busy stays high meanwhile, configuration writes still land.
module wake_light_alarm_controller #(
  parameter int unsigned WAKE_SLOTS       = 8,
  parameter int unsigned PWM_COUNTER_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  wlac_pkg::in_word_t                cmd_word_i,
  output logic                              done_o,
  output wlac_pkg::out_word_t               result_o,
  input  logic                              cfg_we_i,
  input  logic [wlac_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [wlac_pkg::CfgDataW-1:0]     cfg_data_i
);
  import wlac_pkg::*;

  localparam int unsigned SlotW = (WAKE_SLOTS > 1) ? $clog2(WAKE_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(WAKE_SLOTS + 1);
  localparam int unsigned CmpW  = (PWM_COUNTER_BITS > 8) ? PWM_COUNTER_BITS : 8;
  localparam logic [PWM_COUNTER_BITS-1:0] CMax = '1;
  // ceil(2^28/1000); exact division by 1000 for magnitudes below 2^18
  localparam logic [36:0] Recip1000 = 37'd268436;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_ADDW, S_DEL, S_CHK, S_DIV, S_MUL, S_SCALE, S_APPLY,
    S_DONE
  } state_e;

  state_e state_q;
  in_word_t req_q;
  logic [CntW-1:0] idx_q;      // table address being issued
  logic            rd_v_q;     // ram_rd holds valid read data
  logic [7:0] dim_start_q, dim_stop_q, hold_lvl_q, pwm_top_q;
  logic [19:0] ramp_q, hold_q;
  logic [2:0] day_q;
  logic [4:0] hour_q;
  logic [5:0] min_q, sec_q;
  logic [7:0] duty_q;
  logic       run_q, led_q, man_q;
  logic [PWM_COUNTER_BITS-1:0] cnt_q;
  logic [19:0] now_q, best_q;
  logic        found_q;
  logic [1:0]  status_q;
  logic [39:0] rem_q;           // divider remainder / dividend shift
  logic [9:0]  quo_q;
  logic [4:0]  dcnt_q;
  logic signed [19:0] prod_q;
  logic [7:0] new_lvl_q;

  logic ram_we;
  logic [SlotW-1:0] ram_addr;
  logic [EntryW-1:0] ram_wd, ram_rd;

  wlac_ram #(.Width(EntryW), .Depth(WAKE_SLOTS)) u_table (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  // Decode the entry that came back from memory.
  logic        e_en;
  logic [2:0]  e_day;
  logic [4:0]  e_hour;
  logic [5:0]  e_min;
  logic [19:0] e_at, diff;
  assign {e_en, e_day, e_hour, e_min} = ram_rd;
  assign e_at = 20'(e_day - 3'd1) * 20'd86400 + 20'(e_hour) * 20'd3600
              + 20'(e_min) * 20'd60;
  assign diff = now_q - e_at;

  logic valid_dt;
  assign valid_dt = (req_q.day_value != 3'd0) && (req_q.hour_value <= 5'd23)
                  && (req_q.minute_value <= 6'd59);

  logic [SlotW-1:0] idx_s;
  assign idx_s = idx_q[SlotW-1:0];

  // Memory port control.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = idx_s;
    ram_wd   = '0;
    unique case (state_q)
      S_CLEAR: ram_we = 1'b1;
      S_ADDW: begin
        ram_we = 1'b1;
        ram_wd = {1'b1, req_q.day_value, req_q.hour_value, req_q.minute_value};
      end
      S_DEL: begin
        ram_we = rd_v_q;
        ram_wd = {1'b0, ram_rd[EntryW-2:0]};
      end
      default: ;
    endcase
  end

  // Ramp step from quotient and span, divided by 1000 toward zero.
  logic signed [8:0] span;
  logic [17:0] pmag;
  logic [36:0] pscaled;
  logic [8:0]  pquo;
  logic [9:0]  lvl_sum;
  assign span = $signed({1'b0, dim_stop_q}) - $signed({1'b0, dim_start_q});
  assign pmag = prod_q[19] ? 18'(-prod_q) : 18'(prod_q);
  assign pscaled = {19'd0, pmag} * Recip1000;
  assign pquo = pscaled[36:28];
  assign lvl_sum = prod_q[19] ? ({2'd0, dim_start_q} - {1'b0, pquo})
                              : ({2'd0, dim_start_q} + {1'b0, pquo});
  logic [29:0] dvd;
  assign dvd = 30'(best_q) * 30'd1000;
  logic [40:0] trial;
  assign trial = {rem_q[39:20], 1'b0} + 41'(rem_q[19]) - {21'd0, ramp_q};
  logic [20:0] rsum;
  assign rsum = {1'b0, ramp_q} + {1'b0, hold_q};

  // Hold state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; idx_q <= '0; rd_v_q <= 1'b0;
      dim_start_q <= 8'd10; dim_stop_q <= 8'd255; hold_lvl_q <= 8'd255;
      ramp_q <= 20'd1800; hold_q <= 20'd1800; pwm_top_q <= 8'd255;
      day_q <= 3'd1; hour_q <= '0; min_q <= '0; sec_q <= '0;
      duty_q <= '0; run_q <= 1'b0; led_q <= 1'b0; man_q <= 1'b0; cnt_q <= '0;
      done_o <= 1'b0; status_q <= StOk; req_q <= '0;
      now_q <= '0; best_q <= '0; found_q <= 1'b0; rem_q <= '0; quo_q <= '0;
      dcnt_q <= '0; prod_q <= '0; new_lvl_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegDimStart:  dim_start_q <= cfg_data_i[7:0];
          RegDimStop:   dim_stop_q  <= cfg_data_i[7:0];
          RegHoldLevel: hold_lvl_q  <= cfg_data_i[7:0];
          RegRampSec:   ramp_q      <= cfg_data_i;
          RegHoldSec:   hold_q      <= cfg_data_i;
          RegPwmTop:    pwm_top_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          if (idx_q == CntW'(WAKE_SLOTS - 1)) begin
            idx_q <= '0; state_q <= S_IDLE;
          end else idx_q <= idx_q + 1'b1;
        end
        S_IDLE: if (start) begin
          req_q <= cmd_word_i; status_q <= StOk; idx_q <= '0; rd_v_q <= 1'b0;
          state_q <= S_DONE;
          unique case (cmd_word_i.cmd)
            CmdPwmTick: if (run_q) begin
              logic [PWM_COUNTER_BITS-1:0] top, nc;
              top = (PWM_COUNTER_BITS >= 8) ? PWM_COUNTER_BITS'(pwm_top_q)
                  : ((pwm_top_q > 8'(CMax)) ? CMax : PWM_COUNTER_BITS'(pwm_top_q));
              nc = (cnt_q >= top) ? '0 : cnt_q + 1'b1;
              cnt_q <= nc;
              led_q <= (CmpW'(nc) <= CmpW'(duty_q));
            end
            CmdSecTick: begin
              if (sec_q >= 6'd59) begin
                sec_q <= '0;
                if (min_q >= 6'd59) begin
                  min_q <= '0;
                  if (hour_q >= 5'd23) begin
                    hour_q <= '0;
                    day_q <= (day_q >= 3'd7) ? 3'd1 : day_q + 3'd1;
                  end else hour_q <= hour_q + 5'd1;
                end else min_q <= min_q + 6'd1;
              end else sec_q <= sec_q + 6'd1;
            end
            CmdCheck: if (!man_q) begin
              now_q <= 20'(day_q - 3'd1) * 20'd86400 + 20'(hour_q) * 20'd3600
                     + 20'(min_q) * 20'd60 + 20'(sec_q);
              found_q <= 1'b0; state_q <= S_SCAN;
            end
            CmdSetTime: begin
              if (cmd_word_i.day_value == 3'd0 || cmd_word_i.hour_value > 5'd23 ||
                  cmd_word_i.minute_value > 6'd59 || cmd_word_i.second_value > 6'd59)
                status_q <= StBadData;
              else begin
                day_q <= cmd_word_i.day_value; hour_q <= cmd_word_i.hour_value;
                min_q <= cmd_word_i.minute_value; sec_q <= cmd_word_i.second_value;
              end
            end
            CmdAdd: state_q <= S_SCAN;
            CmdDelete: begin
              if (cmd_word_i.slot_index < 8'(WAKE_SLOTS)) begin
                idx_q <= CntW'(cmd_word_i.slot_index); state_q <= S_DEL;
              end else status_q <= StBadSlot;
            end
            CmdManual: begin
              duty_q <= cmd_word_i.intensity_value;
              man_q <= (cmd_word_i.intensity_value != 8'd0);
              if (cmd_word_i.intensity_value == 8'd0) begin
                if (run_q) begin run_q <= 1'b0; led_q <= 1'b0; end
              end else run_q <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // Walk the table: issue next read, look at the previous entry.
          rd_v_q <= 1'b1;
          if (req_q.cmd == CmdAdd) begin
            if (!valid_dt) begin
              status_q <= StBadData; state_q <= S_DONE;
            end else if (rd_v_q && !e_en) begin
              idx_q <= idx_q - 1'b1; state_q <= S_ADDW;
            end else if (idx_q == CntW'(WAKE_SLOTS)) begin
              status_q <= StNoSlot; state_q <= S_DONE;
            end else idx_q <= idx_q + 1'b1;
          end else begin
            if (rd_v_q && e_en && now_q > e_at && (!found_q || diff < best_q)) begin
              best_q <= diff; found_q <= 1'b1;
            end
            if (idx_q == CntW'(WAKE_SLOTS)) state_q <= S_CHK;
            else idx_q <= idx_q + 1'b1;
          end
        end
        S_ADDW: state_q <= S_DONE;
        S_DEL: begin
          if (rd_v_q) state_q <= S_DONE;
          rd_v_q <= 1'b1;
        end
        S_CHK: begin
          // Quotient of 1000*best/ramp fits ten bits since best < ramp.
          if (found_q && {12'd0, best_q} < {12'd0, ramp_q}) begin
            rem_q <= {dvd, 10'd0};
            quo_q <= '0; dcnt_q <= '0; state_q <= S_DIV;
          end else begin
            new_lvl_q <= (found_q && {1'b0, best_q} < rsum) ? hold_lvl_q : 8'd0;
            state_q <= S_APPLY;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle.
          if (!trial[40]) begin
            rem_q <= {trial[19:0], rem_q[18:0], 1'b0};
            quo_q <= {quo_q[8:0], 1'b1};
          end else begin
            rem_q <= {rem_q[38:0], 1'b0};
            quo_q <= {quo_q[8:0], 1'b0};
          end
          if (dcnt_q == 5'd9) state_q <= S_MUL;
          dcnt_q <= dcnt_q + 5'd1;
        end
        S_MUL: begin
          prod_q <= $signed({10'd0, quo_q}) * span;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          new_lvl_q <= lvl_sum[7:0];
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          duty_q <= new_lvl_q;
          if (new_lvl_q == 8'd0) begin
            if (run_q) begin run_q <= 1'b0; led_q <= 1'b0; end
          end else run_q <= 1'b1;
          dcnt_q <= '0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          done_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    result_o.led_on       = led_q;
    result_o.intensity    = duty_q;
    result_o.status       = status_q;
    result_o.clock_day    = day_q;
    result_o.clock_hour   = hour_q;
    result_o.clock_minute = min_q;
    result_o.clock_second = sec_q;
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_led_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> !led_q) else $error("led on while stopped");
  a_clock_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    day_q != 3'd0 && hour_q <= 5'd23 && sec_q <= 6'd59) else $error("bad clock");
`endif

endmodule

>>> verif/wake_light_alarm_controller_test.sv
// Self-checking testbench of the wake light alarm controller: directed table, random words, then a full-table fill.
`timescale 1ns / 1ps

module wake_light_alarm_controller_test;
  import wlac_pkg::*;

  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int unsigned Slots = 8;
  localparam int unsigned WeekSec = 604800;
  localparam int unsigned CycleLimit = 600000;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t cmd_word_i = '0;
  logic done_o;
  out_word_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  wake_light_alarm_controller dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_word_i(cmd_word_i), .done_o(done_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the alarm state
  int lv_start = 10, lv_stop = 255, lv_hold = 255, ramp_len = 1800, hold_len = 1800;
  int pwm_top = 255;
  int clk_day = 1, clk_hour = 0, clk_min = 0, clk_sec = 0;
  bit slot_en [Slots];
  int slot_day [Slots], slot_hour [Slots], slot_min [Slots];
  int duty = 0, pwm_cnt = 0;
  bit pwm_on = 0, manual_hold = 0, led = 0;

  out_word_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;

  function automatic void apply_level(int v);
    duty = v;
    if (v == 0 && pwm_on) begin
      pwm_on = 0;
      led = 0;
    end
    if (v > 0 && !pwm_on) pwm_on = 1;
  endfunction

  function automatic void run_alarm();
    longint now, at, best, q, span;
    if (manual_hold) return;
    now = longint'(clk_day - 1) * 86400 + clk_hour * 3600 + clk_min * 60 + clk_sec;
    best = 64'hffffffff;
    for (int i = 0; i < Slots; i++) begin
      if (!slot_en[i]) continue;
      at = longint'(slot_day[i] - 1) * 86400 + slot_hour[i] * 3600 + slot_min[i] * 60;
      if (now > at && now - at < best) best = now - at;
    end
    if (best < ramp_len) begin
      q = (1000 * best) / ramp_len;
      span = lv_stop - lv_start;
      apply_level(int'((lv_start + (q * span) / 1000) & 255));
    end else if (best < longint'(ramp_len) + hold_len) begin
      apply_level(lv_hold);
    end else begin
      apply_level(0);
    end
  endfunction

  // Advance the mirror by one command word and return its result word
  function automatic out_word_t step_alarm(in_word_t w);
    out_word_t r;
    logic [1:0] st;
    bit placed;
    st = StOk;
    case (w.cmd)
      CmdPwmTick: if (pwm_on) begin
        pwm_cnt = (pwm_cnt >= pwm_top) ? 0 : pwm_cnt + 1;
        led = (pwm_cnt <= duty);
      end
      CmdSecTick: begin
        clk_sec++;
        if (clk_sec >= 60) begin
          clk_sec = 0;
          clk_min++;
          if (clk_min >= 60) begin
            clk_min = 0;
            clk_hour++;
            if (clk_hour >= 24) begin
              clk_hour = 0;
              clk_day++;
              if (clk_day >= 8) clk_day = 1;
            end
          end
        end
      end
      CmdCheck: run_alarm();
      CmdSetTime: begin
        if (w.day_value < 1 || w.hour_value > 23 || w.minute_value > 59 ||
            w.second_value > 59) begin
          st = StBadData;
        end else begin
          clk_day = int'(w.day_value);
          clk_hour = int'(w.hour_value);
          clk_min = int'(w.minute_value);
          clk_sec = int'(w.second_value);
        end
      end
      CmdAdd: begin
        if (w.day_value < 1 || w.hour_value > 23 || w.minute_value > 59) begin
          st = StBadData;
        end else begin
          placed = 0;
          for (int i = 0; i < Slots; i++) begin
            if (!placed && !slot_en[i]) begin
              slot_en[i] = 1;
              slot_day[i] = int'(w.day_value);
              slot_hour[i] = int'(w.hour_value);
              slot_min[i] = int'(w.minute_value);
              placed = 1;
            end
          end
          if (!placed) st = StNoSlot;
        end
      end
      CmdDelete: begin
        if (w.slot_index < Slots) slot_en[w.slot_index] = 0;
        else st = StBadSlot;
      end
      CmdManual: begin
        apply_level(int'(w.intensity_value));
        manual_hold = (w.intensity_value != 0);
      end
      default: ;
    endcase
    r.led_on = led;
    r.intensity = duty[7:0];
    r.status = st;
    r.clock_day = clk_day[2:0];
    r.clock_hour = clk_hour[4:0];
    r.clock_minute = clk_min[5:0];
    r.clock_second = clk_sec[5:0];
    return r;
  endfunction

  // Result checker: compare each result word with the oldest expectation
  task automatic flag_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end else if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        flag_field("led_on", int'(want.led_on), int'(result_o.led_on));
        flag_field("intensity", int'(want.intensity), int'(result_o.intensity));
        flag_field("status", int'(want.status), int'(result_o.status));
        flag_field("clock_day", int'(want.clock_day), int'(result_o.clock_day));
        flag_field("clock_hour", int'(want.clock_hour), int'(result_o.clock_hour));
        flag_field("clock_minute", int'(want.clock_minute), int'(result_o.clock_minute));
        flag_field("clock_second", int'(want.clock_second), int'(result_o.clock_second));
      end
    end
  end

  function automatic in_word_t make_word(logic [2:0] c, int d, int h, int m, int s,
                                          int slot, int lvl);
    in_word_t w;
    w.cmd = c;
    w.day_value = 3'(d);
    w.hour_value = 5'(h);
    w.minute_value = 6'(m);
    w.second_value = 6'(s);
    w.slot_index = 8'(slot);
    w.intensity_value = 8'(lvl);
    return w;
  endfunction

  // Result right after reset: dark, clock at day 1, 00:00:00
  function automatic out_word_t reset_result(logic [1:0] st);
    out_word_t r;
    r = '0;
    r.status = st;
    r.clock_day = 3'd1;
    return r;
  endfunction

  // Send one word; return once it is taken
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    out_word_t model_out;
    start <= 1'b1;
    cmd_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model_out = step_alarm(w);
    pending_results.push_back(typed ? want : model_out);
  endtask

  task automatic sender_gap(int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(posedge clk_i);
    case (idx)
      RegDimStart: lv_start = val & 255;
      RegDimStop: lv_stop = val & 255;
      RegHoldLevel: lv_hold = val & 255;
      RegRampSec: ramp_len = val;
      RegHoldSec: hold_len = val;
      RegPwmTop: pwm_top = val & 255;
      default: ;
    endcase
  endtask

  task automatic load_setting(int s0, int s1, int hl, int rs, int hs, int top);
    write_reg(RegDimStart, s0);
    write_reg(RegDimStop, s1);
    write_reg(RegHoldLevel, hl);
    write_reg(RegRampSec, rs);
    write_reg(RegHoldSec, hs);
    write_reg(RegPwmTop, top);
    cfg_we_i <= 1'b0;
  endtask

  // Random word: mostly meaningful commands, some raw noise
  function automatic in_word_t random_word();
    in_word_t w;
    int r, pick, target, n;
    w = in_word_t'(39'({$urandom, $urandom}));
    r = $urandom_range(0, 99);
    if (r < 12) return w;
    if (r < 30) w.cmd = CmdPwmTick;
    else if (r < 45) w.cmd = CmdSecTick;
    else if (r < 60) w.cmd = CmdCheck;
    else if (r < 68) begin
      w = make_word(CmdSetTime, $urandom_range(1, 7), $urandom_range(0, 23),
                    $urandom_range(0, 59), $urandom_range(0, 59), int'(w.slot_index),
                    int'(w.intensity_value));
    end else if (r < 77) begin
      // Land the clock shortly after a stored wake time
      n = 0;
      pick = -1;
      for (int i = 0; i < Slots; i++)
        if (slot_en[i]) begin
          n++;
          if ($urandom_range(1, n) == 1) pick = i;
        end
      if (pick < 0) begin
        w.cmd = CmdCheck;
      end else begin
        target = (slot_day[pick] - 1) * 86400 + slot_hour[pick] * 3600 + slot_min[pick] * 60;
        if ($urandom_range(0, 3) == 0)
          target += $urandom_range(0, 120);
        else
          target += $urandom_range(0, ramp_len + hold_len + 60);
        if (target >= WeekSec) target = WeekSec - 1;
        w = make_word(CmdSetTime, target / 86400 + 1, (target % 86400) / 3600,
                      (target % 3600) / 60, target % 60, int'(w.slot_index),
                      int'(w.intensity_value));
      end
    end else if (r < 86) begin
      w = make_word(CmdAdd, $urandom_range(1, 7), $urandom_range(0, 23),
                    $urandom_range(0, 59), int'(w.second_value), int'(w.slot_index),
                    int'(w.intensity_value));
    end else if (r < 93) begin
      w.cmd = CmdDelete;
      w.slot_index = 8'($urandom_range(0, 9));
    end else begin
      w.cmd = CmdManual;
      w.intensity_value = ($urandom_range(0, 9) < 6) ? 8'd0 : 8'($urandom_range(1, 255));
    end
    return w;
  endfunction

  step_row_t steps[$];
  int idle_pct [4] = '{0, 72, 0, 22};

  initial begin
    step_row_t row;
    // Error codes and untouched clock straight after reset
    row.typed = 1;
    row.word = make_word(CmdPwmTick, 0, 0, 0, 0, 0, 0); row.want = reset_result(StOk);
    steps.push_back(row);
    row.word = make_word(CmdSetTime, 0, 5, 5, 5, 0, 0); row.want = reset_result(StBadData);
    steps.push_back(row);
    row.word = make_word(CmdSetTime, 7, 24, 0, 0, 0, 0); row.want = reset_result(StBadData);
    steps.push_back(row);
    row.word = make_word(CmdSetTime, 3, 0, 60, 0, 0, 0); row.want = reset_result(StBadData);
    steps.push_back(row);
    row.word = make_word(CmdSetTime, 3, 0, 0, 63, 0, 0); row.want = reset_result(StBadData);
    steps.push_back(row);
    row.word = make_word(CmdAdd, 0, 1, 1, 0, 0, 0); row.want = reset_result(StBadData);
    steps.push_back(row);
    row.word = make_word(CmdAdd, 7, 31, 0, 0, 0, 0); row.want = reset_result(StBadData);
    steps.push_back(row);
    row.word = make_word(CmdAdd, 1, 0, 63, 0, 0, 0); row.want = reset_result(StBadData);
    steps.push_back(row);
    row.word = make_word(CmdDelete, 0, 0, 0, 0, 8, 0); row.want = reset_result(StBadSlot);
    steps.push_back(row);
    row.word = make_word(CmdDelete, 7, 31, 63, 63, 255, 255);
    row.want = reset_result(StBadSlot);
    steps.push_back(row);
    row.word = make_word(CmdUnused, 7, 31, 63, 63, 255, 255); row.want = reset_result(StOk);
    steps.push_back(row);
    row.word = make_word(CmdCheck, 0, 0, 0, 0, 0, 0); row.want = reset_result(StOk);
    steps.push_back(row);
    // Ramp, hold, wrap and override, checked against the mirror
    row.typed = 0;
    row.word = make_word(CmdAdd, 1, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdSetTime, 1, 0, 10, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdCheck, 0, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdPwmTick, 0, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdSetTime, 1, 0, 45, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdCheck, 0, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdSetTime, 7, 23, 59, 59, 0, 0); steps.push_back(row);
    row.word = make_word(CmdSecTick, 0, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdManual, 0, 0, 0, 0, 0, 255); steps.push_back(row);
    row.word = make_word(CmdCheck, 0, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdPwmTick, 0, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdManual, 0, 0, 0, 0, 0, 0); steps.push_back(row);
    row.word = make_word(CmdDelete, 0, 0, 0, 0, 0, 0); steps.push_back(row);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) send_word(steps[i].word, steps[i].typed, steps[i].want);

    // Four phases of random words, each under its own setting and a sender idling rate
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: load_setting(10, 255, 255, 1800, 1800, 255);
        1: load_setting(255, 0, 0, 1, 0, 1);
        2: load_setting(0, 255, 128, 604800, 604800, 255);
        default: load_setting(200, 40, 77, 0, 300, 0);
      endcase
      @(posedge clk_i);
      for (int k = 0; k < 170; k++) begin
        if (ph == 1 && k == 85) begin
          start <= 1'b0;
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_word(random_word(), 0, '0);
        sender_gap(idle_pct[ph]);
      end
    end

    // Fill the table to hit the full-table answer, then run one alarm check
    drain();
    for (int k = 0; k < Slots + 2; k++)
      send_word(make_word(CmdAdd, $urandom_range(1, 7), $urandom_range(0, 23),
                          $urandom_range(0, 59), 0, 0, 0), 0, '0);
    send_word(make_word(CmdCheck, 0, 0, 0, 0, 0, 0), 0, '0);
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
